@@ hdl/hfts_pkg.sv @@
// ----------------------------------------------------------------------------
// hfts_pkg: shared types for the hex float literal parser
// Word formats for the character and result channels, the parse phases,
// the status codes and the parse state record.
// ----------------------------------------------------------------------------
`default_nettype none

package hfts_pkg;

  // parse phases
  typedef enum logic [3:0] {
    PH_WS         = 4'd0,
    PH_SIGNED     = 4'd1,
    PH_KW_NAN     = 4'd2,
    PH_KW_INF     = 4'd3,
    PH_WANT_X     = 4'd4,
    PH_FIRST      = 4'd5,
    PH_INT        = 4'd6,
    PH_FRAC       = 4'd7,
    PH_EXP_SIGN   = 4'd8,
    PH_EXP_FIRST  = 4'd9,
    PH_EXP_DIGITS = 4'd10,
    PH_DONE       = 4'd11
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FORMAT    = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  // characters consumed per step
  typedef enum logic [1:0] {
    ADV_NONE    = 2'd0,
    ADV_ONE     = 2'd1,
    ADV_KEYWORD = 2'd3
  } adv_t;

  localparam logic [31:0] QNAN_BITS = 32'h7fc00000;
  localparam logic [31:0] INF_BITS  = 32'h7f800000;
  localparam logic [31:0] SIGN_BIT  = 32'h80000000;
  localparam int          EXP_BIAS  = 'h7F;
  localparam int          EXP_MAX   = 'hFF;
  localparam int          DEC_LIMIT = 100000;
  localparam int          BIT_START = 28;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic [31:0] value_bits;
    status_t     status;
    logic [12:0] consumed;
  } result_word_t;

  typedef struct packed {
    phase_t             phase;
    logic [1:0]         kw_idx;
    logic               negative;
    logic               exp_neg;
    logic               lead_seen;
    logic [31:0]        frac;
    logic signed [5:0]  bit_pos;
    logic signed [15:0] exp_adj;
    logic [19:0]        dec_exp;
    logic [31:0]        res_value;
    status_t            res_status;
  } parse_t;

  typedef struct packed {
    parse_t p;
    adv_t   adv;
  } step_t;

  localparam parse_t PARSE_RESET = '{
    phase:      PH_WS,
    kw_idx:     2'd0,
    negative:   1'b0,
    exp_neg:    1'b0,
    lead_seen:  1'b0,
    frac:       32'd0,
    bit_pos:    6'(BIT_START),
    exp_adj:    16'sd0,
    dec_exp:    20'd0,
    res_value:  32'd0,
    res_status: ST_OK
  };

endpackage

`default_nettype wire

@@ hdl/hex_float_text_to_single.sv @@
// ----------------------------------------------------------------------------
// hex_float_text_to_single: streaming hex float literal to IEEE single
// Takes one character per word and returns the single precision bit
// pattern, a status and the consumed count on the word that carries last.
// ----------------------------------------------------------------------------
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+------------------------------
//   char      | char_valid / char_ready    | char_word   (ch, last)
//   result    | result_valid / result_ready| result_word (value, status, n)
//   config    | cfg_wr_en                  | cfg_wr_data (require full str)
//
// one character word per cycle, sustained, unless a last word waits on a
// full result register; a last word goes from the input register through
// the parse step into the result register
// the parse step runs the character and, on last, the implicit terminator
// in the same cycle, so throughput is set by that single step
// reset (synchronous, rst high) clears the parse state and the config bit
// a stalled result holds only words that carry last; others keep flowing
//
`default_nettype none

module hex_float_text_to_single
  import hfts_pkg::*;
#(
  parameter int MAX_CHARS = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data,
  input  wire logic         char_valid,
  output logic              char_ready,
  input  wire char_word_t   char_word,
  output logic              result_valid,
  input  wire logic         result_ready,
  output result_word_t      result_word
);

  localparam int CNT_W = $clog2(MAX_CHARS + 1);

  // ---------------------------------------------------------------------
  // character helpers
  // ---------------------------------------------------------------------

  // {valid, digit value}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // saturating add to the exponent adjustment
  function automatic logic signed [15:0] adj_sat(logic signed [15:0] a,
                                                 logic signed [3:0] d);
    logic signed [16:0] sum;
    sum = {a[15], a} + {{13{d[3]}}, d};
    if (sum > 17'sd32767) sum = 17'sd32767;
    if (sum < -17'sd32768) sum = -17'sd32768;
    return sum[15:0];
  endfunction

  // digit below the leading one
  function automatic parse_t place_digit(parse_t s, logic [3:0] d);
    parse_t n;
    logic [5:0] sh;
    logic [35:0] wide;
    logic signed [5:0] nb;
    n = s;
    sh = 6'(s.bit_pos + 6'sd4);
    wide = {32'd0, d} << sh;
    n.frac = s.frac | wide[35:4];
    nb = s.bit_pos - 6'sd4;
    if (nb < -6'sd4) nb = -6'sd4;
    n.bit_pos = nb;
    return n;
  endfunction

  // first nonzero digit: leading one drops off the top
  function automatic step_t lead_digit(parse_t s, logic [3:0] d);
    step_t r;
    logic [1:0] used;
    r.p = s;
    r.adv = ADV_NONE;
    if (d[3]) begin
      r.p.frac = {d[2:0], 29'd0};
      used = 2'd3;
    end else if (d[2]) begin
      r.p.frac = {d[1:0], 30'd0};
      used = 2'd2;
    end else if (d[1]) begin
      r.p.frac = {d[0], 31'd0};
      used = 2'd1;
    end else begin
      used = 2'd0;
    end
    r.p.bit_pos = s.bit_pos - 6'(used);
    r.p.lead_seen = 1'b1;
    // used count handed back through adv field
    r.adv = adv_t'(used);
    return r;
  endfunction

  function automatic parse_t finish(parse_t s, logic [31:0] v, status_t st);
    parse_t n;
    n = s;
    n.res_value = v;
    n.res_status = st;
    n.phase = PH_DONE;
    return n;
  endfunction

  function automatic parse_t finalize(parse_t s);
    logic [31:0] sign;
    logic signed [21:0] e;
    logic signed [21:0] b;
    sign = s.negative ? SIGN_BIT : 32'd0;
    e = {2'b00, s.dec_exp};
    if (s.exp_neg) e = -e;
    b = e + 22'(EXP_BIAS) + {{6{s.exp_adj[15]}}, s.exp_adj};
    if (!s.lead_seen) return finish(s, sign, ST_OK);
    if (b < 22'sd0) return finish(s, sign, ST_UNDERFLOW);
    if (b > 22'(EXP_MAX)) return finish(s, sign | INF_BITS, ST_OVERFLOW);
    return finish(s, {s.negative, b[7:0], s.frac[31:9]}, ST_OK);
  endfunction

  // after an optional sign: inf keyword or 0x prefix
  function automatic step_t signed_stage(parse_t s, logic [7:0] c,
                                         logic [7:0] lc);
    step_t r;
    r.p = s;
    r.adv = ADV_NONE;
    if (lc == "i") begin
      r.p.phase = PH_KW_INF;
      r.p.kw_idx = 2'd1;
    end else if (c == "0") begin
      r.adv = ADV_ONE;
      r.p.phase = PH_WANT_X;
    end else begin
      r.p = finish(s, 32'd0, ST_FORMAT);
    end
    return r;
  endfunction

  function automatic step_t exp_first(parse_t s, logic [7:0] c);
    step_t r;
    r.p = s;
    r.adv = ADV_NONE;
    if (c >= "0" && c <= "9") begin
      r.adv = ADV_ONE;
      r.p.dec_exp = 20'(c - "0");
      r.p.phase = PH_EXP_DIGITS;
    end else begin
      r.p = finish(s, 32'd0, ST_FORMAT);
    end
    return r;
  endfunction

  // one character through the parser
  function automatic step_t feed(parse_t s, logic [7:0] c, logic req);
    step_t r;
    step_t ld;
    logic [4:0] hx;
    logic [7:0] lc;
    logic [7:0] kw_ch;
    logic [23:0] dec10;
    r.p = s;
    r.adv = ADV_NONE;
    hx = hex_val(c);
    lc = to_lower(c);
    ld = lead_digit(s, hx[3:0]);
    kw_ch = 8'd0;
    dec10 = {1'b0, s.dec_exp, 3'd0} + {3'd0, s.dec_exp, 1'b0} + 24'(c - "0");
    case (s.phase)
      PH_WS: begin
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
          r.adv = ADV_ONE;
        end else if (lc == "n") begin
          r.p.phase = PH_KW_NAN;
          r.p.kw_idx = 2'd1;
        end else if (c == "+" || c == "-") begin
          r.p.negative = (c == "-");
          r.adv = ADV_ONE;
          r.p.phase = PH_SIGNED;
        end else begin
          r = signed_stage(s, c, lc);
        end
      end
      PH_SIGNED: r = signed_stage(s, c, lc);
      PH_KW_NAN, PH_KW_INF: begin
        case (s.kw_idx)
          2'd0: kw_ch = (s.phase == PH_KW_NAN) ? "n" : "i";
          2'd1: kw_ch = (s.phase == PH_KW_NAN) ? "a" : "n";
          2'd2: kw_ch = (s.phase == PH_KW_NAN) ? "n" : "f";
          default: kw_ch = 8'd0;
        endcase
        if (s.kw_idx == 2'd3 || lc != kw_ch) begin
          r.p = finish(s, 32'd0, ST_FORMAT);
        end else if (s.kw_idx == 2'd2) begin
          r.adv = ADV_KEYWORD;
          if (s.phase == PH_KW_NAN) r.p = finish(s, QNAN_BITS, ST_OK);
          else r.p = finish(s, (s.negative ? SIGN_BIT : 32'd0) | INF_BITS, ST_OK);
        end else begin
          r.p.kw_idx = s.kw_idx + 2'd1;
        end
      end
      PH_WANT_X: begin
        if (lc == "x") begin
          r.adv = ADV_ONE;
          r.p.phase = PH_FIRST;
        end else begin
          r.p = finish(s, 32'd0, ST_FORMAT);
        end
      end
      PH_FIRST, PH_INT: begin
        if (hx[4]) begin
          r.adv = ADV_ONE;
          if (s.lead_seen) begin
            r.p = place_digit(s, hx[3:0]);
            r.p.exp_adj = adj_sat(s.exp_adj, 4'sd4);
          end else if (hx[3:0] != 4'd0) begin
            r.p = ld.p;
            r.p.exp_adj = adj_sat(s.exp_adj, $signed({2'b00, ld.adv}));
          end
          r.p.phase = PH_INT;
        end else if (s.phase == PH_INT && c == ".") begin
          r.adv = ADV_ONE;
          r.p.phase = PH_FRAC;
        end else if (s.phase == PH_INT && lc == "p") begin
          r.adv = ADV_ONE;
          r.p.phase = PH_EXP_SIGN;
        end else begin
          r.p = finish(s, 32'd0, ST_FORMAT);
        end
      end
      PH_FRAC: begin
        if (hx[4]) begin
          r.adv = ADV_ONE;
          if (s.lead_seen) begin
            r.p = place_digit(s, hx[3:0]);
          end else if (hx[3:0] != 4'd0) begin
            r.p = ld.p;
            r.p.exp_adj = adj_sat(s.exp_adj, $signed({2'b00, ld.adv}) - 4'sd4);
          end else begin
            r.p.exp_adj = adj_sat(s.exp_adj, -4'sd4);
          end
        end else if (lc == "p") begin
          r.adv = ADV_ONE;
          r.p.phase = PH_EXP_SIGN;
        end else begin
          r.p = finish(s, 32'd0, ST_FORMAT);
        end
      end
      PH_EXP_SIGN: begin
        if (c == "+" || c == "-") begin
          r.p.exp_neg = (c == "-");
          r.adv = ADV_ONE;
          r.p.phase = PH_EXP_FIRST;
        end else begin
          r = exp_first(s, c);
        end
      end
      PH_EXP_FIRST: r = exp_first(s, c);
      PH_EXP_DIGITS: begin
        if (c >= "0" && c <= "9") begin
          r.adv = ADV_ONE;
          if (s.dec_exp < 20'(DEC_LIMIT)) r.p.dec_exp = dec10[19:0];
        end else if (c != 8'd0 && req) begin
          r.p = finish(s, 32'd0, ST_FORMAT);
        end else begin
          r.p = finalize(s);
        end
      end
      default: r.p = s;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------

  logic             require_full;
  logic             s1_valid;
  char_word_t       s1_word;
  logic             s1_fire;
  parse_t           st;
  parse_t           st_next;
  logic [CNT_W-1:0] char_count;
  logic [CNT_W-1:0] char_count_next;
  result_word_t     result_next;
  step_t            step1;
  step_t            step2;
  logic [CNT_W:0]   cnt_sum;

  // config bit
  always_ff @(posedge clk) begin
    if (rst) begin
      require_full <= 1'b0;
    end else if (cfg_wr_en) begin
      require_full <= cfg_wr_data;
    end
  end

  // the input stage moves on unless it holds a last word and the result
  // register is still occupied and not being read
  assign s1_fire    = s1_valid && (!s1_word.last || !result_valid || result_ready);
  assign char_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ready) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      s1_word <= char_word;
    end
  end

  // ---------------------------------------------------------------------
  // parse step: the character, then on last the implicit terminator
  // ---------------------------------------------------------------------

  always_comb begin
    if (st.phase != PH_DONE) begin
      step1 = feed(st, s1_word.ch, require_full);
    end else begin
      step1.p = st;
      step1.adv = ADV_NONE;
    end

    // terminator never consumes a character
    if (step1.p.phase != PH_DONE) begin
      step2 = feed(step1.p, 8'd0, require_full);
    end else begin
      step2.p = step1.p;
      step2.adv = ADV_NONE;
    end

    cnt_sum = {1'b0, char_count} + (CNT_W+1)'(step1.adv);
    if (cnt_sum > (CNT_W+1)'(MAX_CHARS)) begin
      cnt_sum = (CNT_W+1)'(MAX_CHARS);
    end

    result_next.value_bits = step2.p.res_value;
    result_next.status     = step2.p.res_status;
    result_next.consumed   = 13'(cnt_sum[CNT_W-1:0]);

    // a finished string returns the parser to its reset state
    if (s1_word.last) begin
      st_next = PARSE_RESET;
      char_count_next = '0;
    end else begin
      st_next = step1.p;
      char_count_next = cnt_sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_RESET;
      char_count <= '0;
    end else if (s1_fire) begin
      st <= st_next;
      char_count <= char_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && s1_word.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_word.last) begin
      result_word <= result_next;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // a stalled input stage keeps its word
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_word))
    else $error("input stage lost a stalled word");

  // the parser restarts after every last word
  a_restart: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_word.last |=> st.phase == PH_WS && char_count == '0)
    else $error("parse state not cleared after last word");

  // character count saturates
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    char_count <= CNT_W'(MAX_CHARS))
    else $error("character count above limit");

  // format errors return positive zero
  a_fmt_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.status == ST_FORMAT |-> result_word.value_bits == 32'd0)
    else $error("format error with nonzero value");

endmodule

`default_nettype wire

@@ verif/hex_float_text_to_single_test.sv @@
// ----------------------------------------------------------------------------
// hex_float_text_to_single_test: self-checking bench for the hex float parser
// Feeds hex float literals one character word at a time, predicts each
// result word from its own model of the parse and checks every field.
// Directed strings cover keywords, errors, the exponent extremes and the
// digit and bit position limits; random literals, broken literals and noise
// follow.
// ----------------------------------------------------------------------------

import hfts_pkg::*;

typedef logic [7:0] octet_t;

localparam int CHAR_CAP = 4096;

// scoreboard with a built-in model of the parse
class parse_scoreboard;
  int errors;
  int live_chars;
  int strings;
  int by_status[4];

  local bit                 full_string;
  local result_word_t       want_q[$];
  local phase_t             stage;
  local logic [1:0]         kw_pos;
  local logic               neg;
  local logic               exp_neg;
  local logic               lead_seen;
  local logic [31:0]        frac;
  local logic signed [5:0]  bit_pos;
  local logic signed [15:0] exp_adj;
  local logic [19:0]        dec_exp;
  local logic [12:0]        n_chars;
  local logic [31:0]        held_value;
  local status_t            held_status;

  function new();
    errors = 0;
    live_chars = 0;
    strings = 0;
    by_status = '{default: 0};
    full_string = 1'b0;
    clear();
  endfunction

  function void set_full_string(bit v);
    full_string = v;
  endfunction

  function int pending();
    return want_q.size();
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  local function void clear();
    stage = PH_WS;
    kw_pos = 2'd0;
    neg = 1'b0;
    exp_neg = 1'b0;
    lead_seen = 1'b0;
    frac = 32'd0;
    bit_pos = 6'(BIT_START);
    exp_adj = 16'sd0;
    dec_exp = 20'd0;
    n_chars = 13'd0;
    held_value = 32'd0;
    held_status = ST_OK;
  endfunction

  local function void count(int n);
    int t;
    t = int'(n_chars) + n;
    n_chars = 13'((t > CHAR_CAP) ? CHAR_CAP : t);
  endfunction

  local function void adjust(int n);
    int t;
    t = int'(exp_adj) + n;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    exp_adj = 16'(t);
  endfunction

  // digit below the leading one
  local function void place(int d);
    int t;
    if (bit_pos >= 0) frac |= d << bit_pos;
    else if (bit_pos > -4) frac |= d >> (-int'(bit_pos));
    t = int'(bit_pos) - 4;
    bit_pos = 6'((t < -4) ? -4 : t);
  endfunction

  // first nonzero digit, its top one drops off the register
  local function int lead(int d);
    int used;
    if (d >= 8) begin
      frac = d << 29;
      used = 3;
    end else if (d >= 4) begin
      frac = d << 30;
      used = 2;
    end else if (d >= 2) begin
      frac = d << 31;
      used = 1;
    end else begin
      used = 0;
    end
    bit_pos = 6'(int'(bit_pos) - used);
    lead_seen = 1'b1;
    return used;
  endfunction

  local function void settle(logic [31:0] value, status_t st);
    held_value = value;
    held_status = st;
    stage = PH_DONE;
  endfunction

  local function void reject();
    settle(32'd0, ST_FORMAT);
  endfunction

  local function void feed(octet_t c);
    int h;
    int biased;
    octet_t lc;
    octet_t want;
    logic [31:0] sign;
    if (c >= "0" && c <= "9") h = c - "0";
    else if (c >= "a" && c <= "f") h = c - "a" + 10;
    else if (c >= "A" && c <= "F") h = c - "A" + 10;
    else h = -1;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    sign = neg ? SIGN_BIT : 32'd0;
    case (stage)
      PH_WS, PH_SIGNED: begin
        if (stage == PH_WS && (c == " " || (c >= 8'd9 && c <= 8'd13))) begin
          count(1);
        end else if (stage == PH_WS && lc == "n") begin
          stage = PH_KW_NAN;
          kw_pos = 2'd1;
        end else if (stage == PH_WS && (c == "+" || c == "-")) begin
          neg = (c == "-");
          count(1);
          stage = PH_SIGNED;
        end else if (lc == "i") begin
          stage = PH_KW_INF;
          kw_pos = 2'd1;
        end else if (c == "0") begin
          count(1);
          stage = PH_WANT_X;
        end else begin
          reject();
        end
      end
      PH_KW_NAN, PH_KW_INF: begin
        if (stage == PH_KW_NAN) want = (kw_pos == 2'd1) ? "a" : "n";
        else want = (kw_pos == 2'd1) ? "n" : "f";
        if (kw_pos > 2'd2 || lc != want) begin
          reject();
        end else begin
          kw_pos++;
          if (kw_pos == 2'd3) begin
            count(3);
            if (stage == PH_KW_NAN) settle(QNAN_BITS, ST_OK);
            else settle(sign | INF_BITS, ST_OK);
          end
        end
      end
      PH_WANT_X: begin
        if (lc == "x") begin
          count(1);
          stage = PH_FIRST;
        end else begin
          reject();
        end
      end
      PH_FIRST, PH_INT: begin
        if (h >= 0) begin
          count(1);
          if (lead_seen) begin
            place(h);
            adjust(4);
          end else if (h > 0) begin
            adjust(lead(h));
          end
          stage = PH_INT;
        end else if (stage == PH_INT && c == ".") begin
          count(1);
          stage = PH_FRAC;
        end else if (stage == PH_INT && lc == "p") begin
          count(1);
          stage = PH_EXP_SIGN;
        end else begin
          reject();
        end
      end
      PH_FRAC: begin
        if (h >= 0) begin
          count(1);
          if (lead_seen) place(h);
          else if (h > 0) adjust(lead(h) - 4);
          else adjust(-4);
        end else if (lc == "p") begin
          count(1);
          stage = PH_EXP_SIGN;
        end else begin
          reject();
        end
      end
      PH_EXP_SIGN, PH_EXP_FIRST: begin
        if (stage == PH_EXP_SIGN && (c == "+" || c == "-")) begin
          exp_neg = (c == "-");
          count(1);
          stage = PH_EXP_FIRST;
        end else if (c >= "0" && c <= "9") begin
          count(1);
          dec_exp = 20'(c - "0");
          stage = PH_EXP_DIGITS;
        end else begin
          reject();
        end
      end
      PH_EXP_DIGITS: begin
        if (c >= "0" && c <= "9") begin
          count(1);
          if (dec_exp < DEC_LIMIT) dec_exp = 20'(dec_exp * 10 + (c - "0"));
        end else if (c != 8'd0 && full_string) begin
          reject();
        end else if (!lead_seen) begin
          settle(sign, ST_OK);
        end else begin
          biased = (exp_neg ? -int'(dec_exp) : int'(dec_exp)) + EXP_BIAS + int'(exp_adj);
          if (biased < 0) settle(sign, ST_UNDERFLOW);
          else if (biased > EXP_MAX) settle(sign | INF_BITS, ST_OVERFLOW);
          else settle(sign | (frac >> 9) | (32'(biased) << 23), ST_OK);
        end
      end
      default: ;
    endcase
  endfunction

  function void note_char(char_word_t w);
    if (stage != PH_DONE) begin
      live_chars++;
      feed(w.ch);
    end
    if (w.last) begin
      if (stage != PH_DONE) feed(8'd0);
      want_q.push_back('{value_bits: held_value, status: held_status, consumed: n_chars});
      by_status[held_status]++;
      strings++;
      clear();
    end
  endfunction

  function void check_result(result_word_t got);
    result_word_t want;
    if (want_q.size() == 0) begin
      flag($sformatf("result word with nothing expected: value %h status %0d consumed %0d",
                     got.value_bits, got.status, got.consumed));
      return;
    end
    want = want_q.pop_front();
    if (got.value_bits !== want.value_bits || got.status !== want.status ||
        got.consumed !== want.consumed)
      flag($sformatf("mismatch (expected/actual): value %h/%h status %0d/%0d consumed %0d/%0d",
                     want.value_bits, got.value_bits, want.status, got.status,
                     want.consumed, got.consumed));
  endfunction
endclass

module hex_float_text_to_single_test;

  localparam int CLK_PERIOD = 8;

  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_wr_en;
  logic         cfg_wr_data;
  logic         char_valid;
  logic         char_ready;
  char_word_t   char_word;
  logic         result_valid;
  logic         result_ready;
  result_word_t result_word;

  parse_scoreboard sb = new();

  // no idling on either side once set
  bit calm = 1'b0;

  // characters of the string being built
  octet_t text_q[$];

  hex_float_text_to_single #(
    .MAX_CHARS(CHAR_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_word(char_word),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_word(result_word)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // hex digit character, letters in random case
  function automatic octet_t hex_char(int v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // sends the built string, last on its final word; each word is noted
  // in the scoreboard at the edge that takes it
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        // sender gap with junk on the payload
        char_valid <= 1'b0;
        char_word <= char_word_t'($urandom_range(0, 511));
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      char_valid <= 1'b1;
      char_word <= '{ch: text_q[i], last: (i == text_q.size() - 1)};
      do @(posedge clk); while (!char_ready);
      sb.note_char(char_word);
    end
    text_q.delete();
  endtask

  task automatic send_str(string s);
    put_text(s);
    send_text();
  endtask

  // the register changes only with no string in flight
  task automatic write_full_string(bit v);
    char_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_full_string(v);
  endtask

  task automatic run_directed();
    send_str("0x1p0");
    send_str("-0x1.8p1");
    // every whitespace character ahead of a keyword
    text_q = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
    put_text("nan");
    send_text();
    send_str("NaN");
    send_str("-inf");
    send_str("+INF");
    // keywords never look at what follows
    send_str("infinity");
    // sign ahead of nan is refused
    send_str("-nan");
    // partial keywords
    send_str("nax");
    send_str("in");
    // zero mantissa with an exponent past the digit cap
    send_str("0x0.000p99999999");
    // biased exponent of zero and of all ones, then just past each end
    send_str("0x1.8p-127");
    send_str("0x1.8p128");
    send_str("0x1p129");
    send_str("-0x1p-128");
    // missing digits, missing prefix, missing exponent
    send_str("0x.8p0");
    send_str("0x");
    send_str("1.0");
    send_str("0xAp");
    send_str("0x1p+");
    // long mantissa runs the bit position to its floor
    send_str("0xfEdCbA9876.54321p-40");
    // trailing text, matters only when the full string is required
    send_str("0x00001.0p+2 x");
    // terminator then more text, ignored up to last
    put_text("0x1p3");
    text_q.push_back(8'd0);
    put_text("zz");
    send_text();
    // empty string and a non-ascii character
    text_q.push_back(8'd0);
    send_text();
    text_q.push_back(8'hff);
    send_text();
    send_str("0X0.0001P0");
  endtask

  // random strings until target characters have been parsed
  task automatic random_run(int target);
    int start;
    int n;
    int pick;
    string kw;
    octet_t c;
    start = sb.live_chars;
    while (sb.live_chars - start < target) begin
      repeat ($urandom_range(0, 2))
        text_q.push_back(($urandom_range(0, 3) == 0) ? 8'd32 : 8'($urandom_range(9, 13)));
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        // hex literal, well formed below 70, damaged above
        case ($urandom_range(0, 2))
          1: text_q.push_back("+");
          2: text_q.push_back("-");
          default: ;
        endcase
        text_q.push_back("0");
        text_q.push_back($urandom_range(0, 1) ? "x" : "X");
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0) repeat (n) text_q.push_back("0");
        else repeat (n) text_q.push_back(hex_char($urandom_range(0, 15)));
        if ($urandom_range(0, 1)) begin
          text_q.push_back(".");
          repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0) text_q.push_back("0");
          repeat ($urandom_range(0, 6)) text_q.push_back(hex_char($urandom_range(0, 15)));
        end
        text_q.push_back($urandom_range(0, 1) ? "p" : "P");
        case ($urandom_range(0, 2))
          1: text_q.push_back("+");
          2: text_q.push_back("-");
          default: ;
        endcase
        if ($urandom_range(0, 7) == 0) text_q.push_back("0");
        put_text($sformatf("%0d", ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9999999)
                                                               : $urandom_range(0, 160)));
        case ($urandom_range(0, 5))
          0: begin
            text_q.push_back(8'd0);
            repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
          end
          1: text_q.push_back(8'($urandom_range(32, 126)));
          default: ;
        endcase
        if (pick >= 70) begin
          n = $urandom_range(0, text_q.size() - 1);
          if ($urandom_range(0, 1)) text_q[n] = 8'($urandom_range(0, 255));
          else text_q = text_q[0:n];
        end
      end else if (pick < 90) begin
        // keyword, random case, sometimes signed, misspelled or followed by ity
        case ($urandom_range(0, 3))
          1: text_q.push_back("+");
          2: text_q.push_back("-");
          default: ;
        endcase
        kw = $urandom_range(0, 1) ? "nan" : "inf";
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3;
        for (int i = 0; i < 3; i++) begin
          c = kw[i];
          if ($urandom_range(0, 1)) c = c - 8'd32;
          if (i == n) c = 8'($urandom_range(97, 122));
          text_q.push_back(c);
        end
        if ($urandom_range(0, 3) == 0) put_text("ity");
      end else begin
        // noise over the whole character range
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      send_text();
    end
  endtask

  // result side: checks each taken word, stalls in random bursts
  initial begin : result_sink
    int hold;
    hold = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) sb.check_result(result_word);
      if (hold == 0 && !calm && $urandom_range(0, 15) == 0) hold = $urandom_range(1, 16);
      if (hold > 0) begin
        hold--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    char_valid <= 1'b0;
    char_word <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed strings under both register settings
    write_full_string(1'b0);
    run_directed();
    write_full_string(1'b1);
    run_directed();

    // random literals, trailing text refused
    random_run(400);

    // trailing text tolerated
    write_full_string(1'b0);
    random_run(400);

    // long integer part runs the bit position to its floor and grows
    // the exponent adjustment
    put_text("0x1");
    repeat (40) text_q.push_back(hex_char($urandom_range(0, 15)));
    put_text($sformatf("p-%0d", $urandom_range(0, 400)));
    send_text();
    // run of fraction zeros ahead of the leading one drives it negative
    put_text("-0x0.");
    repeat (40) text_q.push_back("0");
    text_q.push_back(hex_char($urandom_range(1, 15)));
    put_text($sformatf("p+%0d", $urandom_range(0, 400)));
    send_text();

    // last stretch at full rate on both sides
    write_full_string(1'b1);
    calm = 1'b1;
    random_run(400);

    // drain, then leave room for any stray result word
    char_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.flag($sformatf("%0d result words never arrived", sb.pending()));

    $display("parsed %0d characters in %0d strings, trailing text both refused and allowed",
             sb.live_chars, sb.strings);
    $display("outcomes: %0d ok, %0d format error, %0d overflow, %0d underflow; %0d mismatches",
             sb.by_status[ST_OK], sb.by_status[ST_FORMAT], sb.by_status[ST_OVERFLOW],
             sb.by_status[ST_UNDERFLOW], sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #(CLK_PERIOD * 2000000);
    $display("timeout with %0d result words outstanding", sb.pending());
    $display("FAIL");
    $finish;
  end

endmodule
